/* rtl/ipc_pkg.sv */
// ipc_pkg: shared constants, types and the palette rom of the iteration palette colorizer
// no dependencies; used by the interfaces, ipc_blend and iteration_palette_colorizer
package ipc_pkg;

  localparam int LIM_W              = 16;
  localparam int CHAN_W             = 8;
  localparam int PALETTE_ENTRIES    = 16;
  localparam int IDX_W              = $clog2(PALETTE_ENTRIES);
  localparam int COUNT_BITS_DEF     = 16;
  localparam int PALETTE_CYCLES_DEF = 6;
  localparam int FRACTION_BITS_DEF  = 8;

  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(256);

  // [2] red, [1] green, [0] blue
  typedef logic [2:0][CHAN_W-1:0] rgb_t;

  // control group between the phase pipeline and the blend stages
  typedef struct packed {
    logic valid;
    logic in_set;
  } phase_ctl_t;

  function automatic rgb_t palette_color(input logic [IDX_W-1:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = {8'd0,   8'd7,   8'd100};
      4'd1:    c = {8'd12,  8'd44,  8'd138};
      4'd2:    c = {8'd24,  8'd82,  8'd177};
      4'd3:    c = {8'd57,  8'd125, 8'd209};
      4'd4:    c = {8'd134, 8'd181, 8'd229};
      4'd5:    c = {8'd211, 8'd236, 8'd248};
      4'd6:    c = {8'd241, 8'd250, 8'd255};
      4'd7:    c = {8'd255, 8'd255, 8'd255};
      4'd8:    c = {8'd255, 8'd238, 8'd170};
      4'd9:    c = {8'd255, 8'd215, 8'd85};
      4'd10:   c = {8'd255, 8'd170, 8'd0};
      4'd11:   c = {8'd230, 8'd135, 8'd0};
      4'd12:   c = {8'd190, 8'd95,  8'd0};
      4'd13:   c = {8'd140, 8'd70,  8'd0};
      4'd14:   c = {8'd90,  8'd40,  8'd0};
      4'd15:   c = {8'd0,   8'd7,   8'd100};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/ipc_if.sv */
// ipc_if: valid/ready channel interfaces for pixel counts, colors and the limit register
// depends on ipc_pkg
interface ipc_in_if #(
  parameter int COUNT_BITS = ipc_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

interface ipc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ipc_pkg::CHAN_W-1:0]  red;
  logic [ipc_pkg::CHAN_W-1:0]  green;
  logic [ipc_pkg::CHAN_W-1:0]  blue;
  logic                        inside_set;

  modport source (output valid, output red, output green, output blue, output inside_set,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input inside_set,
                  output ready);
endinterface

interface ipc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ipc_pkg::LIM_W-1:0]  max_iterations;

  modport source (output valid, output max_iterations, input ready);
  modport sink   (input valid, input max_iterations, output ready);
endinterface

/* rtl/ipc_blend.sv */
// ipc_blend: palette rom lookup stage and linear blend output stage
// depends on ipc_pkg and ipc_out_if
module ipc_blend #(
  parameter int FRACTION_BITS = ipc_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ipc_pkg::phase_ctl_t           ctl,
  output logic                          in_ready,
  input  logic [ipc_pkg::IDX_W-1:0]     left,
  input  logic [FRACTION_BITS-1:0]      frac,
  ipc_out_if.source                     color
);

  localparam int IDX_W  = ipc_pkg::IDX_W;
  localparam int CHAN_W = ipc_pkg::CHAN_W;
  localparam int WF_W   = FRACTION_BITS + 1;
  localparam int PW     = CHAN_W + FRACTION_BITS + 1;
  localparam int unsigned ONE = 1 << FRACTION_BITS;

  // lookup stage
  logic                     v0;
  logic                     inside0;
  ipc_pkg::rgb_t            cl;
  ipc_pkg::rgb_t            cr;
  logic [FRACTION_BITS-1:0] f0;

  // output stage
  logic                     v1;
  logic                     inside1;
  ipc_pkg::rgb_t            rgb1;
  ipc_pkg::rgb_t            rgb_next;

  logic mv0, mv1;
  logic [WF_W-1:0] wl;

  assign mv1      = !v1 || color.ready;
  assign mv0      = !v0 || mv1;
  assign in_ready = mv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (mv0) v0 <= ctl.valid;
      if (mv1) v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv0) begin
      inside0 <= ctl.in_set;
      cl      <= ipc_pkg::palette_color(left);
      cr      <= ipc_pkg::palette_color(left + IDX_W'(1));
      f0      <= frac;
    end
    if (mv1) begin
      inside1 <= inside0;
      rgb1    <= rgb_next;
    end
  end

  assign wl = WF_W'(ONE) - WF_W'(f0);

  always_comb begin
    logic [PW-1:0] acc;
    rgb_next = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = PW'(cl[ch]) * PW'(wl) + PW'(cr[ch]) * PW'(f0);
      rgb_next[ch] = inside0 ? '0 : acc[FRACTION_BITS +: CHAN_W];
    end
  end

  assign color.valid      = v1;
  assign color.red        = rgb1[2];
  assign color.green      = rgb1[1];
  assign color.blue       = rgb1[0];
  assign color.inside_set = inside1;

  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    color.valid && color.inside_set |-> color.red == '0 && color.green == '0
                                        && color.blue == '0)
    else $error("pixel inside the set is not black");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> v0 && v1 && !color.ready)
    else $error("blend stages refuse a word while not full");

endmodule

/* rtl/iteration_palette_colorizer.sv */
// iteration_palette_colorizer: top level, limit register and the phase division pipeline
// depends on ipc_pkg, ipc_if and ipc_blend
//
// Usage: one escape-iteration count per word enters on the pixel channel and one
// color word (red, green, blue, inside_set) leaves on the color channel, in order.
// A count at or above max_iterations gives black with inside_set high.
// The limit is written through the cfg channel, which is always ready; write it
// only while no pixel is in flight. Reset sets the limit to 256 and empties the
// pipeline; no clearing pass is needed.
// Throughput: one pixel per cycle while the receiver keeps color.ready high. The path
// holds 4 + clog2(PALETTE_CYCLES) + clog2(15) + FRACTION_BITS register stages, 19 with
// the default parameters. An input stage forms count * PALETTE_CYCLES, then each
// stage does one restoring compare-subtract step against the limit for the phase
// remainder, a stage scales it by 15, more such steps give the palette index bits
// and then the fraction bits, followed by a rom stage and a blend stage.
// When the receiver stalls, every stage holding a word keeps it and bubbles
// close up, so pixel.ready only drops once all stages are full.
module iteration_palette_colorizer #(
  parameter int COUNT_BITS     = ipc_pkg::COUNT_BITS_DEF,
  parameter int PALETTE_CYCLES = ipc_pkg::PALETTE_CYCLES_DEF,
  parameter int FRACTION_BITS  = ipc_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ipc_in_if.sink    pixel,
  ipc_out_if.source color,
  ipc_cfg_if.sink   cfg
);

  localparam int LIM_W  = ipc_pkg::LIM_W;
  localparam int IDX_W  = ipc_pkg::IDX_W;
  localparam int CMP_W  = (COUNT_BITS > LIM_W) ? COUNT_BITS : LIM_W;
  localparam int CYC_QB = $clog2(PALETTE_CYCLES);
  localparam int LQB    = $clog2(ipc_pkg::PALETTE_ENTRIES - 1);
  localparam int EXT0   = (CYC_QB > LQB) ? CYC_QB : LQB;
  localparam int EXT    = (EXT0 > 1) ? EXT0 : 1;
  localparam int AW     = LIM_W + EXT;
  localparam int MUL_K  = CYC_QB + 1;
  localparam int LQ_END = MUL_K + LQB;
  localparam int NS     = LQ_END + FRACTION_BITS;

  typedef struct packed {
    logic                     in_set;
    logic [AW-1:0]            acc;
    logic [IDX_W-1:0]         left;
    logic [FRACTION_BITS-1:0] frac;
  } rec_t;

  logic [LIM_W-1:0] lim;

  wire rec_t      rec [0:NS];
  wire [NS:0]     v;
  wire [NS+1:0]   mv;
  logic           blend_ready;
  ipc_pkg::phase_ctl_t ctl;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= ipc_pkg::LIM_RESET;
    end else if (cfg.valid && cfg.ready) begin
      lim <= cfg.max_iterations;
    end
  end

  assign mv[NS+1]   = blend_ready;
  assign pixel.ready = mv[0];

  for (genvar k = 0; k <= NS; k++) begin : stg
    rec_t nxt;
    rec_t q;
    logic vq;
    logic vin;

    if (k == 0) begin : g_in
      logic [CMP_W-1:0] count_ext;
      assign vin       = pixel.valid;
      assign count_ext = CMP_W'(pixel.iteration_count);
      always_comb begin
        nxt        = '0;
        nxt.in_set = count_ext >= CMP_W'(lim);
        // phase numerator, only meaningful below the limit
        nxt.acc    = AW'(count_ext[LIM_W-1:0]) * AW'(PALETTE_CYCLES);
      end
    end else if (k < MUL_K) begin : g_mod
      localparam int J = MUL_K - 1 - k;
      logic [AW-1:0] lim_sh;
      assign vin    = v[k-1];
      assign lim_sh = AW'(lim) << J;
      always_comb begin
        nxt = rec[k-1];
        if (rec[k-1].acc >= lim_sh) nxt.acc = rec[k-1].acc - lim_sh;
      end
    end else if (k == MUL_K) begin : g_mul
      assign vin = v[k-1];
      always_comb begin
        nxt     = rec[k-1];
        nxt.acc = rec[k-1].acc * AW'(ipc_pkg::PALETTE_ENTRIES - 1);
      end
    end else if (k <= LQ_END) begin : g_idx
      localparam int J = LQ_END - k;
      logic [AW-1:0] lim_sh;
      assign vin    = v[k-1];
      assign lim_sh = AW'(lim) << J;
      always_comb begin
        nxt = rec[k-1];
        if (rec[k-1].acc >= lim_sh) begin
          nxt.acc     = rec[k-1].acc - lim_sh;
          nxt.left[J] = 1'b1;
        end
      end
    end else begin : g_frac
      logic [AW-1:0] t;
      assign vin = v[k-1];
      assign t   = rec[k-1].acc << 1;
      always_comb begin
        nxt = rec[k-1];
        if (t >= AW'(lim)) begin
          nxt.acc  = t - AW'(lim);
          nxt.frac = {rec[k-1].frac[FRACTION_BITS-2:0], 1'b1};
        end else begin
          nxt.acc  = t;
          nxt.frac = {rec[k-1].frac[FRACTION_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq <= 1'b0;
      end else if (mv[k]) begin
        vq <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (mv[k]) q <= nxt;
    end

    assign v[k]   = vq;
    assign rec[k] = q;
    // a stage loads when empty or when its word moves on
    assign mv[k]  = !vq || mv[k+1];
  end

  assign ctl.valid  = v[NS];
  assign ctl.in_set = rec[NS].in_set;

  ipc_blend #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_blend (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .in_ready(blend_ready),
    .left    (rec[NS].left),
    .frac    (rec[NS].frac),
    .color   (color)
  );

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> &v)
    else $error("pixel refused while the phase pipeline has a bubble");

  a_tail_hold: assert property (@(posedge clk) disable iff (rst)
    v[NS] && !blend_ready |=> v[NS] && $stable(rec[NS]))
    else $error("stalled phase word lost or changed");

  a_first_hold: assert property (@(posedge clk) disable iff (rst)
    v[0] && !mv[1] |=> v[0] && $stable(rec[0]))
    else $error("stalled input stage word lost or changed");

endmodule
